FILE: src/assert_macros.svh
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, ck, rn, expr, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/ssvs_pkg.sv
// Types, constants and table functions of the sine source.
package ssvs_pkg;

	localparam int TIME_W      = 48;
	localparam int TURN_W      = 32;
	localparam int AMP_W       = 24;
	localparam int VOLT_W      = 26;
	localparam int SLOPE_W     = 32;
	localparam int SIN_W       = 32;
	localparam int QUARTER_W   = 31;
	localparam int SCALED_W    = 25;
	localparam int SLOPE_PRE_W = 30;
	localparam int OMEGA_W     = 32;
	localparam int SIN_FRAC    = 30;
	localparam int OMEGA_FRAC  = 29;
	localparam int CFG_W       = 32;
	localparam int ADDR_W      = 4;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 64;

	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint ONE_Q30     = 64'sd1073741824;
	localparam logic [OMEGA_W-1:0] TWO_PI_Q29 = 32'd3373259426;

	localparam logic signed [AMP_W-1:0] AMPLITUDE_RST = 24'sd65536;
	localparam logic signed [AMP_W-1:0] DC_OFFSET_RST = 24'sd0;
	localparam logic [TURN_W-1:0]       FREQUENCY_RST = 32'd257698;
	localparam logic [TURN_W-1:0]       PHASE_RST     = 32'd0;
	localparam logic [2*TURN_W-1:0] OMEGA_PROD_RST =
		(2*TURN_W)'(FREQUENCY_RST) * (2*TURN_W)'(TWO_PI_Q29);
	localparam logic [OMEGA_W-1:0] OMEGA_RST = OMEGA_PROD_RST[2*TURN_W-1 -: OMEGA_W];

	typedef enum logic [1:0] {
		REG_AMPLITUDE,
		REG_DC_OFFSET,
		REG_FREQUENCY,
		REG_PHASE_OFFSET
	} reg_idx_t;

	typedef struct packed {
		logic signed [AMP_W-1:0] amplitude;
		logic signed [AMP_W-1:0] dc_offset;
		logic [TURN_W-1:0]       frequency;
		logic [TURN_W-1:0]       phase_offset;
		logic [OMEGA_W-1:0]      omega;
	} cfg_t;

	// floor((v + 2^(k-1)) / 2^k)
	function automatic longint round_shift(input longint v, input int unsigned k);
		return (v + (longint'(1) << (k - 1))) >>> k;
	endfunction

	// sin(pi/2 * k / 2^(tbits-2)) in Q1.30 by Taylor series through x^13
	function automatic logic [QUARTER_W-1:0] quarter_sin(input int unsigned k,
		input int unsigned tbits);
		longint r;
		longint x;
		longint x2;
		longint term;
		longint sum;
		r = longint'(k) << (TURN_W - tbits);
		x = round_shift(r * HALF_PI_Q30, SIN_FRAC);
		x2 = round_shift(x * x, SIN_FRAC);
		term = x;
		sum = x;
		term = -(round_shift(term * x2, SIN_FRAC) / 6);
		sum = sum + term;
		term = -(round_shift(term * x2, SIN_FRAC) / 20);
		sum = sum + term;
		term = -(round_shift(term * x2, SIN_FRAC) / 42);
		sum = sum + term;
		term = -(round_shift(term * x2, SIN_FRAC) / 72);
		sum = sum + term;
		term = -(round_shift(term * x2, SIN_FRAC) / 110);
		sum = sum + term;
		term = -(round_shift(term * x2, SIN_FRAC) / 156);
		sum = sum + term;
		if (sum > ONE_Q30) sum = ONE_Q30;
		if (sum < 0) sum = 0;
		return QUARTER_W'(sum);
	endfunction

endpackage

FILE: src/ssvs_cfg.sv
// Configuration registers behind the APB port, with the angular rate per tick.
module ssvs_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ssvs_pkg::ADDR_W-1:0]  paddr,
	input  logic [ssvs_pkg::CFG_W-1:0]   pwdata,
	output logic [ssvs_pkg::CFG_W-1:0]   prdata,
	output logic                         pready,
	output ssvs_pkg::cfg_t               cfg
);
	import ssvs_pkg::*;

	logic signed [AMP_W-1:0] amplitude_q;
	logic signed [AMP_W-1:0] dc_offset_q;
	logic [TURN_W-1:0]       frequency_q;
	logic [TURN_W-1:0]       phase_offset_q;
	logic [OMEGA_W-1:0]      omega_q;
	logic [2*TURN_W-1:0]     omega_prod;
	logic                    wr_en;
	reg_idx_t                reg_idx;

	assign pready     = 1'b1;
	assign wr_en      = psel && penable && pwrite && pready;
	assign reg_idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign omega_prod = (2*TURN_W)'(frequency_q) * (2*TURN_W)'(TWO_PI_Q29);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q    <= AMPLITUDE_RST;
			dc_offset_q    <= DC_OFFSET_RST;
			frequency_q    <= FREQUENCY_RST;
			phase_offset_q <= PHASE_RST;
			omega_q        <= OMEGA_RST;
		end else begin
			omega_q <= omega_prod[2*TURN_W-1 -: OMEGA_W];
			if (wr_en) begin
				case (reg_idx)
					REG_AMPLITUDE:    amplitude_q    <= pwdata[AMP_W-1:0];
					REG_DC_OFFSET:    dc_offset_q    <= pwdata[AMP_W-1:0];
					REG_FREQUENCY:    frequency_q    <= pwdata[TURN_W-1:0];
					REG_PHASE_OFFSET: phase_offset_q <= pwdata[TURN_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (reg_idx)
			REG_AMPLITUDE:    prdata = CFG_W'(unsigned'(amplitude_q));
			REG_DC_OFFSET:    prdata = CFG_W'(unsigned'(dc_offset_q));
			REG_FREQUENCY:    prdata = frequency_q;
			REG_PHASE_OFFSET: prdata = phase_offset_q;
			default:          prdata = '0;
		endcase
	end

	assign cfg.amplitude    = amplitude_q;
	assign cfg.dc_offset    = dc_offset_q;
	assign cfg.frequency    = frequency_q;
	assign cfg.phase_offset = phase_offset_q;
	assign cfg.omega        = omega_q;

endmodule

FILE: src/ssvs_phase.sv
// Phase stages: frequency times time, plus phase offset, cut to a table index.
module ssvs_phase #(
	parameter int PHASE_BITS      = 32,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ssvs_pkg::cfg_t               cfg,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ssvs_pkg::TURN_W-1:0]  in_time,
	input  logic                         in_reversed,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [SINE_TABLE_BITS-1:0]   out_index,
	output logic                         out_reversed
);
	import ssvs_pkg::*;

	localparam int TB       = SINE_TABLE_BITS;
	localparam int PW       = (PHASE_BITS < TURN_W) ? PHASE_BITS : TURN_W;
	localparam int IDX_BITS = (PW < TB) ? PW : TB;

	logic              vld_s1;
	logic              vld_s2;
	logic              rdy_s1;
	logic              rdy_s2;
	logic [TURN_W-1:0] prod_s1;
	logic              rev_s1;
	logic [TB-1:0]     idx_s2;
	logic              rev_s2;
	logic [TURN_W-1:0] phase_c;

	assign rdy_s2   = !vld_s2 || out_ready;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign phase_c  = prod_s1 + cfg.phase_offset;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			prod_s1 <= TURN_W'(cfg.frequency * in_time);
			rev_s1  <= in_reversed;
		end
		if (rdy_s2 && vld_s1) begin
			idx_s2 <= TB'(phase_c[TURN_W-1 -: IDX_BITS]) << (TB - IDX_BITS);
			rev_s2 <= rev_s1;
		end
	end

	assign out_valid    = vld_s2;
	assign out_index    = idx_s2;
	assign out_reversed = rev_s2;

endmodule

FILE: src/ssvs_sine.sv
// Sine and cosine lookup from a quarter-wave table.
module ssvs_sine #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [SINE_TABLE_BITS-1:0]         in_index,
	input  logic                               in_reversed,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [ssvs_pkg::SIN_W-1:0]  out_sin,
	output logic signed [ssvs_pkg::SIN_W-1:0]  out_cos,
	output logic                               out_reversed
);
	import ssvs_pkg::*;

	localparam int TB = SINE_TABLE_BITS;
	localparam int QN = 2 ** (TB - 2);
	localparam int KW = TB - 1;

	logic [QUARTER_W-1:0]    qtab [QN+1];
	logic [1:0]              quad_sin;
	logic [1:0]              quad_cos;
	logic [TB-3:0]           frac;
	logic [KW-1:0]           k_sin;
	logic [KW-1:0]           k_cos;
	logic signed [SIN_W-1:0] sin_c;
	logic signed [SIN_W-1:0] cos_c;
	logic                    vld_s3;
	logic                    rdy_s3;
	logic signed [SIN_W-1:0] sin_s3;
	logic signed [SIN_W-1:0] cos_s3;
	logic                    rev_s3;

	for (genvar g = 0; g <= QN; g++) begin : g_qtab
		assign qtab[g] = quarter_sin(g, TB);
	end

	// fold into the first quarter, mirror on odd quarters, negate on the lower half
	always_comb begin
		quad_sin = in_index[TB-1 -: 2];
		quad_cos = quad_sin + 2'd1;
		frac     = in_index[TB-3:0];
		k_sin    = quad_sin[0] ? (KW'(QN) - KW'(frac)) : KW'(frac);
		k_cos    = quad_cos[0] ? (KW'(QN) - KW'(frac)) : KW'(frac);
		sin_c    = quad_sin[1] ? -$signed(SIN_W'(qtab[k_sin])) : $signed(SIN_W'(qtab[k_sin]));
		cos_c    = quad_cos[1] ? -$signed(SIN_W'(qtab[k_cos])) : $signed(SIN_W'(qtab[k_cos]));
	end

	assign rdy_s3   = !vld_s3 || out_ready;
	assign in_ready = rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy_s3) begin
			vld_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && in_valid) begin
			sin_s3 <= sin_c;
			cos_s3 <= cos_c;
			rev_s3 <= in_reversed;
		end
	end

	assign out_valid    = vld_s3;
	assign out_sin      = sin_s3;
	assign out_cos      = cos_s3;
	assign out_reversed = rev_s3;

endmodule

FILE: src/ssvs_scale.sv
// Scaling stages: amplitude times sine plus offset, amplitude times cosine times rate.
module ssvs_scale (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  ssvs_pkg::cfg_t                           cfg,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic signed [ssvs_pkg::SIN_W-1:0]        in_sin,
	input  logic signed [ssvs_pkg::SIN_W-1:0]        in_cos,
	input  logic                                     in_reversed,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [ssvs_pkg::VOLT_W-1:0]       out_voltage,
	output logic signed [ssvs_pkg::SLOPE_PRE_W-1:0]  out_slope,
	output logic                                     out_reversed
);
	import ssvs_pkg::*;

	localparam int PROD_W = AMP_W + SIN_W;
	localparam int DP_W   = SCALED_W + OMEGA_W + 1;
	localparam logic signed [PROD_W-1:0] HALF_SIN = PROD_W'(1) << (SIN_FRAC - 1);
	localparam logic signed [DP_W-1:0]   HALF_OMG = DP_W'(1) << (OMEGA_FRAC - 1);

	logic signed [PROD_W-1:0]      psin;
	logic signed [PROD_W-1:0]      pcos;
	logic signed [PROD_W-1:0]      psin_sh;
	logic signed [PROD_W-1:0]      pcos_sh;
	logic signed [DP_W-1:0]        dprod;
	logic signed [DP_W-1:0]        dprod_sh;
	logic signed [VOLT_W-1:0]      volt_c;
	logic                          vld_s4;
	logic                          vld_s5;
	logic                          rdy_s4;
	logic                          rdy_s5;
	logic signed [SCALED_W-1:0]    as_s4;
	logic signed [SCALED_W-1:0]    ac_s4;
	logic                          rev_s4;
	logic signed [VOLT_W-1:0]      volt_s5;
	logic signed [SLOPE_PRE_W-1:0] slope_s5;
	logic                          rev_s5;

	assign psin     = $signed(cfg.amplitude) * in_sin;
	assign pcos     = $signed(cfg.amplitude) * in_cos;
	assign psin_sh  = (psin + HALF_SIN) >>> SIN_FRAC;
	assign pcos_sh  = (pcos + HALF_SIN) >>> SIN_FRAC;
	assign volt_c   = as_s4 + $signed(cfg.dc_offset);
	assign dprod    = ac_s4 * $signed({1'b0, cfg.omega});
	assign dprod_sh = (dprod + HALF_OMG) >>> OMEGA_FRAC;

	assign rdy_s5   = !vld_s5 || out_ready;
	assign rdy_s4   = !vld_s4 || rdy_s5;
	assign in_ready = rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy_s4) vld_s4 <= in_valid;
			if (rdy_s5) vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && in_valid) begin
			as_s4  <= psin_sh[SCALED_W-1:0];
			ac_s4  <= pcos_sh[SCALED_W-1:0];
			rev_s4 <= in_reversed;
		end
		if (rdy_s5 && vld_s4) begin
			volt_s5  <= volt_c;
			slope_s5 <= dprod_sh[SLOPE_PRE_W-1:0];
			rev_s5   <= rev_s4;
		end
	end

	assign out_valid    = vld_s5;
	assign out_voltage  = volt_s5;
	assign out_slope    = slope_s5;
	assign out_reversed = rev_s5;

endmodule

FILE: src/ssvs_out.sv
// Output stage: orientation sign, widening and packing into the result register.
module ssvs_out (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic signed [ssvs_pkg::VOLT_W-1:0]       in_voltage,
	input  logic signed [ssvs_pkg::SLOPE_PRE_W-1:0]  in_slope,
	input  logic                                     in_reversed,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic [ssvs_pkg::OUT_TDATA_W-1:0]         out_data
);
	import ssvs_pkg::*;

	localparam int PAD_W = OUT_TDATA_W - VOLT_W - SLOPE_W;

	logic signed [VOLT_W-1:0]      volt_c;
	logic signed [SLOPE_PRE_W-1:0] slope_c;
	logic                          vld_s6;
	logic                          rdy_s6;
	logic signed [VOLT_W-1:0]      volt_s6;
	logic signed [SLOPE_W-1:0]     slope_s6;

	// both results stay well inside their ranges, so negation needs no clipping
	assign volt_c  = in_reversed ? -in_voltage : in_voltage;
	assign slope_c = in_reversed ? -in_slope : in_slope;

	assign rdy_s6   = !vld_s6 || out_ready;
	assign in_ready = rdy_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (rdy_s6) begin
			vld_s6 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6 && in_valid) begin
			volt_s6  <= volt_c;
			slope_s6 <= SLOPE_W'(slope_c);
		end
	end

	assign out_valid = vld_s6;
	assign out_data  = {PAD_W'(0), slope_s6, volt_s6};

endmodule

FILE: src/sine_source_value_and_slope.sv
// Top level of the sine source: value and slope at a sample time.
//
// The input stream carries one item per sample: time_ticks in tdata and the
// reversed flag in tuser. Each accepted item gives one result item with the
// source voltage and its slope per tick, both negated when reversed is set.
// The four registers (amplitude, dc_offset, frequency_per_tick,
// phase_offset) sit on the APB port at byte addresses 0, 4, 8 and 12.
// They are to be written while no item is in flight; the block itself does not enforce this.
//
// Six register stages: phase multiply, phase add, table lookup, amplitude
// multiply, rate multiply, and the output register. One item is accepted every
// cycle when the receiver keeps tready high. Reset clears all stage valid bits
// and loads the register defaults. When the receiver stalls, the result is
// held in the output register and items move up into empty stages; the input
// stalls once the whole pipe is full.
module sine_source_value_and_slope #(
	parameter int PHASE_BITS      = 32,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [ssvs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [47:0] time_ticks
	input  logic [0:0]                          s_axis_tuser,   // [0] reversed
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [ssvs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [25:0] voltage, [57:26] slope
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ssvs_pkg::ADDR_W-1:0]         paddr,
	input  logic [ssvs_pkg::CFG_W-1:0]          pwdata,
	output logic [ssvs_pkg::CFG_W-1:0]          prdata,
	output logic                                pready
);
	import ssvs_pkg::*;

	cfg_t                          cfg;
	logic                          ph_valid;
	logic                          ph_ready;
	logic [SINE_TABLE_BITS-1:0]    ph_index;
	logic                          ph_rev;
	logic                          sn_valid;
	logic                          sn_ready;
	logic signed [SIN_W-1:0]       sn_sin;
	logic signed [SIN_W-1:0]       sn_cos;
	logic                          sn_rev;
	logic                          sc_valid;
	logic                          sc_ready;
	logic signed [VOLT_W-1:0]      sc_voltage;
	logic signed [SLOPE_PRE_W-1:0] sc_slope;
	logic                          sc_rev;

	ssvs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ssvs_phase #(
		.PHASE_BITS      (PHASE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_phase (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_time      (s_axis_tdata[TURN_W-1:0]),
		.in_reversed  (s_axis_tuser[0]),
		.out_valid    (ph_valid),
		.out_ready    (ph_ready),
		.out_index    (ph_index),
		.out_reversed (ph_rev)
	);

	ssvs_sine #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_sine (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (ph_valid),
		.in_ready     (ph_ready),
		.in_index     (ph_index),
		.in_reversed  (ph_rev),
		.out_valid    (sn_valid),
		.out_ready    (sn_ready),
		.out_sin      (sn_sin),
		.out_cos      (sn_cos),
		.out_reversed (sn_rev)
	);

	ssvs_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (sn_valid),
		.in_ready     (sn_ready),
		.in_sin       (sn_sin),
		.in_cos       (sn_cos),
		.in_reversed  (sn_rev),
		.out_valid    (sc_valid),
		.out_ready    (sc_ready),
		.out_voltage  (sc_voltage),
		.out_slope    (sc_slope),
		.out_reversed (sc_rev)
	);

	ssvs_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (sc_valid),
		.in_ready    (sc_ready),
		.in_voltage  (sc_voltage),
		.in_slope    (sc_slope),
		.in_reversed (sc_rev),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (m_axis_tdata)
	);

endmodule

FILE: src/ssvs_checker.sv
// Port-level assertions for the sine source and their binding to the top level.
`include "assert_macros.svh"

module ssvs_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tready,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [ssvs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input logic                              pready
);
	import ssvs_pkg::*;

	localparam int PAD_LO = VOLT_W + SLOPE_W;

	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
	`ASSERT_IMPLIES(a_in_ready, clk, arst_n, !m_axis_tvalid || m_axis_tready, s_axis_tready, "input stalled while the output can move")
	`ASSERT_IMPLIES(a_pad_zero, clk, arst_n, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1:PAD_LO] == '0, "result padding not zero")
	`ASSERT_ALWAYS(a_pready, clk, arst_n, pready, "register port not ready")

endmodule

bind sine_source_value_and_slope ssvs_checker u_ssvs_checker (.*);

FILE: sim/tb.sv
// Testbench of the sine source: streams sample times, predicts value and slope, checks results.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ssvs_pkg::*;

	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint ONE_Q30 = 64'sd1073741824;
	localparam logic [63:0] TWO_PI_Q29 = 64'd3373259426;
	localparam longint VOLT_MAX = 64'sd33554431;
	localparam longint VOLT_MIN = -64'sd33554432;
	localparam longint SLOPE_MAX = 64'sd2147483647;
	localparam longint SLOPE_MIN = -64'sd2147483648;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [47:0] ticks;
		logic        reversed;
	} sample_t;

	typedef struct {
		logic signed [25:0] voltage;
		logic signed [31:0] slope;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;   // [47:0] time_ticks
	logic [0:0] s_axis_tuser = '0;              // [0] reversed
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;       // [25:0] voltage, [57:26] slope
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [CFG_W-1:0] pwdata = '0;
	logic [CFG_W-1:0] prdata;
	logic pready;

	logic signed [23:0] amplitude_set = 24'sd65536;
	logic signed [23:0] dc_offset_set = 24'sd0;
	logic [31:0] frequency_set = 32'd257698;
	logic [31:0] phase_offset_set = 32'd0;

	sample_t sample_times[$];
	reading_t due_readings[$];
	sample_t next_sample;
	logic in_fire = 1'b0;
	logic calm = 1'b0;
	int failures = 0;
	int cycles = 0;

	sine_source_value_and_slope dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint round_half_up(input longint v, input int k);
		longint w;
		w = v + (64'sd1 <<< (k - 1));
		return w >>> k;
	endfunction

	function automatic longint sine_q30(input logic [31:0] turns);
		longint r;
		longint x;
		longint x2;
		longint term;
		longint sum;
		longint divisor;
		r = longint'(turns[29:0]);
		if (turns[30]) begin
			r = ONE_Q30 - r;
		end
		x = round_half_up(r * HALF_PI_Q30, 30);
		x2 = round_half_up(x * x, 30);
		term = x;
		sum = x;
		for (int n = 1; n <= 6; n++) begin
			divisor = longint'((2 * n) * (2 * n + 1));
			term = round_half_up(term * x2, 30);
			term = -(term / divisor);
			sum = sum + term;
		end
		if (sum > ONE_Q30) begin
			sum = ONE_Q30;
		end
		if (sum < -ONE_Q30) begin
			sum = -ONE_Q30;
		end
		return turns[31] ? -sum : sum;
	endfunction

	function automatic reading_t source_reading(input logic [47:0] ticks, input logic reversed);
		logic [31:0] phase;
		logic [31:0] index;
		logic [63:0] omega_prod;
		longint omega;
		longint v;
		longint d;
		longint ac;
		reading_t res;
		phase = 32'(ticks * frequency_set);
		phase = phase + phase_offset_set;
		index = {phase[31:22], 22'd0};
		v = round_half_up(longint'(amplitude_set) * sine_q30(index), 30)
			+ longint'(dc_offset_set);
		omega_prod = {32'd0, frequency_set} * TWO_PI_Q29;
		omega = {32'd0, omega_prod[63:32]};
		ac = round_half_up(longint'(amplitude_set) * sine_q30(index + 32'h4000_0000), 30);
		d = round_half_up(ac * omega, 29);
		if (reversed) begin
			v = -v;
			d = -d;
		end
		if (v > VOLT_MAX) v = VOLT_MAX;
		if (v < VOLT_MIN) v = VOLT_MIN;
		if (d > SLOPE_MAX) d = SLOPE_MAX;
		if (d < SLOPE_MIN) d = SLOPE_MIN;
		res.voltage = v[25:0];
		res.slope = d[31:0];
		return res;
	endfunction

	// drive input items
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || in_fire) begin
			if (sample_times.size() > 0 && (calm || $urandom_range(99) >= 19)) begin
				next_sample = sample_times.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= next_sample.ticks;
				s_axis_tuser <= next_sample.reversed;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= arst_n && (calm || $urandom_range(99) >= 19);
	end

	always @(posedge clk) begin : monitor
		reading_t want;
		logic signed [25:0] got_voltage;
		logic signed [31:0] got_slope;
		in_fire <= s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				due_readings.push_back(source_reading(s_axis_tdata[47:0], s_axis_tuser[0]));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got_voltage = m_axis_tdata[25:0];
				got_slope = m_axis_tdata[57:26];
				if (due_readings.size() == 0) begin
					$error("result item with no expectation: voltage %0d slope %0d",
						got_voltage, got_slope);
					failures++;
				end else begin
					want = due_readings.pop_front();
					if (got_voltage !== want.voltage) begin
						$error("voltage: expected %0d, got %0d", want.voltage, got_voltage);
						failures++;
					end
					if (got_slope !== want.slope) begin
						$error("slope: expected %0d, got %0d", want.slope, got_slope);
						failures++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_AMPLITUDE: amplitude_set = data[23:0];
			REG_DC_OFFSET: dc_offset_set = data[23:0];
			REG_FREQUENCY: frequency_set = data;
			REG_PHASE_OFFSET: phase_offset_set = data;
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_all(input logic [23:0] amp, input logic [23:0] dc,
		input logic [31:0] freq, input logic [31:0] phase);
		write_reg(REG_AMPLITUDE, {8'($urandom), amp});
		write_reg(REG_DC_OFFSET, {8'($urandom), dc});
		write_reg(REG_FREQUENCY, freq);
		write_reg(REG_PHASE_OFFSET, phase);
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (sample_times.size() != 0 || s_axis_tvalid || due_readings.size() != 0);
	endtask

	task automatic add_sample(input logic [47:0] ticks, input logic reversed);
		sample_t s;
		s.ticks = ticks;
		s.reversed = reversed;
		sample_times.push_back(s);
	endtask

	function automatic logic [23:0] pick_volts();
		case ($urandom_range(5))
			0: return 24'h7F_FFFF;
			1: return 24'h80_0000;
			2: return 24'($urandom_range(0, 131072)) - 24'd65536;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_turns();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 1 << 20);
			default: return $urandom;
		endcase
	endfunction

	task automatic add_random_samples(input int count);
		logic [47:0] t;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(3))
				0: t = 48'({$urandom, $urandom});
				1: t = 48'($urandom_range(0, 20000));
				2: t = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 1000));
				default: t = 48'($urandom);
			endcase
			add_sample(t, 1'($urandom_range(1)));
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_sample(48'd0, 1'b0);
		add_sample(48'd0, 1'b1);
		add_sample(48'd1, 1'b0);
		add_sample(48'd4167, 1'b0);
		add_sample(48'd8334, 1'b1);
		add_sample(48'd12500, 1'b0);
		add_sample(48'hFFFF_FFFF_FFFF, 1'b0);
		add_sample(48'hFFFF_FFFF_FFFF, 1'b1);
		wait_drained();

		// quarter turn per tick lands on every quadrant boundary
		write_all(24'h7F_FFFF, 24'h7F_FFFF, 32'h4000_0000, 32'd0);
		for (int i = 0; i < 8; i++) begin
			add_sample(48'(i), 1'(i % 2));
		end
		wait_drained();

		write_all(24'h80_0000, 24'h80_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_sample(48'd0, 1'b0);
		add_sample(48'd1, 1'b1);
		add_sample(48'hFFFF_FFFF_FFFF, 1'b1);
		add_sample(48'h8000_0000_0000, 1'b0);
		wait_drained();

		write_all(24'd0, 24'd0, 32'd0, 32'h8000_0000);
		add_sample(48'h5555_5555_5555, 1'b0);
		add_sample(48'hAAAA_AAAA_AAAA, 1'b1);
		wait_drained();

		for (int p = 0; p < 8; p++) begin
			write_all(pick_volts(), pick_volts(), pick_turns(), pick_turns());
			calm = (p == 3);
			add_random_samples(50);
			wait_drained();
		end
		calm = 1'b0;

		repeat (20) @(posedge clk);
		if (due_readings.size() != 0) begin
			$error("%0d expected results never arrived", due_readings.size());
			failures++;
		end
		if (failures == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+src
src/ssvs_pkg.sv
src/ssvs_cfg.sv
src/ssvs_phase.sv
src/ssvs_sine.sv
src/ssvs_scale.sv
src/ssvs_out.sv
src/sine_source_value_and_slope.sv
src/ssvs_checker.sv
sim/tb.sv
